>>> rtl/core/sfvg_pkg.sv
// Shared types, constants and the sine table generator of the sphere face vertex generator.
package sfvg_pkg;

  localparam int MAX_FACES_DEF      = 256;
  localparam int ANGLE_BITS_DEF     = 12;
  localparam int SINE_FRAC_BITS_DEF = 14;

  localparam int RADIUS_W = 16;
  localparam int CNT_W    = 9;
  localparam int IDX_W    = 8;
  localparam int VIDX_W   = 19;
  localparam int CORNER_W = 3;
  localparam int POS_W    = 17;
  localparam int PROD_W   = 17;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_STEPS   = 4;

  localparam logic [CORNER_W-1:0] CORNER_FIRST = 3'd0;
  localparam logic [CORNER_W-1:0] CORNER_LAST  = 3'd5;

  localparam logic [1:0] REG_RADIUS    = 2'd0;
  localparam logic [1:0] REG_RING_CNT  = 2'd1;
  localparam logic [1:0] REG_SEG_CNT   = 2'd2;

  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Unsigned 64-bit quotient by shift and subtract, used only while building the table.
  function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Quarter-wave sine entry k in unsigned Q1.fbits, from a Q.30 Taylor series.
  function automatic longint unsigned quarter_sine(int unsigned k, int unsigned abits,
                                                   int unsigned fbits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint          sum;
    x    = (longint'(k) * TWO_PI_Q30) >> abits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      term = (term * x2) >> 30;
      term = div_u64(term, longint'(2 * n) * longint'(2 * n + 1));
      if ((n % 2) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    v = ((longint'(sum) << fbits) + (64'd1 << 29)) >> 30;
    if (v > (64'd1 << fbits)) v = 64'd1 << fbits;
    return v;
  endfunction

endpackage

>>> rtl/core/sphere_face_vertex_generator_top.sv
// Top level of the sphere face vertex generator: register port, front end, queue, back end.
//
// A transaction on the command side names one face of a latitude/longitude sphere by its
// ring and segment; the block answers with the face's six vertices, one per clock cycle,
// each shown for a single cycle with valid high, corners zero through five in order and
// last set on the sixth. The receiver cannot stall the output, so valid simply follows
// the emission sequencer. Faces outside the programmed counts are taken and yield nothing.
// The back end emits one vertex per cycle; the front end's boundary divider works through
// the angle bits after the accepting edge and then hands the face to the two-entry queue
// once that queue has room, so busy is high while each face is divided and stays high
// while that queue is full. The user must write radius and the counts through the
// register port only while the block is idle; the block itself has no check that
// enforces it. Radius sits at byte 0, ring_count at byte 4, segment_count at byte 8.
module sphere_face_vertex_generator_top #(
  parameter int MAX_FACES      = sfvg_pkg::MAX_FACES_DEF,
  parameter int ANGLE_BITS     = sfvg_pkg::ANGLE_BITS_DEF,
  parameter int SINE_FRAC_BITS = sfvg_pkg::SINE_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [sfvg_pkg::ADDR_W-1:0]          paddr,
  input  logic [sfvg_pkg::DATA_W-1:0]          pwdata,
  output logic [sfvg_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [sfvg_pkg::IDX_W-1:0]           ring,
  input  logic [sfvg_pkg::IDX_W-1:0]           segment,
  output logic                                 valid,
  output logic [sfvg_pkg::VIDX_W-1:0]          vertex_index,
  output logic [sfvg_pkg::CORNER_W-1:0]        corner,
  output logic signed [sfvg_pkg::POS_W-1:0]    pos_x,
  output logic signed [sfvg_pkg::POS_W-1:0]    pos_y,
  output logic signed [sfvg_pkg::POS_W-1:0]    pos_z,
  output logic                                 tex_u,
  output logic                                 tex_v,
  output logic                                 last
);
  import sfvg_pkg::*;

  localparam int QW = VIDX_W + 4 * ANGLE_BITS;

  logic [RADIUS_W-1:0] radius;
  logic [CNT_W-1:0]    ring_count;
  logic [CNT_W-1:0]    segment_count;
  logic                push;
  logic                pop;
  logic [QW-1:0]       push_data;
  logic [QW-1:0]       pop_data;
  q_stat_t             q_stat;

  // The register port never inserts wait states.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius        <= '0;
      ring_count    <= '0;
      segment_count <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_RADIUS:   radius        <= pwdata[RADIUS_W-1:0];
        REG_RING_CNT: ring_count    <= pwdata[CNT_W-1:0];
        REG_SEG_CNT:  segment_count <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RADIUS:   prdata = DATA_W'(radius);
      REG_RING_CNT: prdata = DATA_W'(ring_count);
      REG_SEG_CNT:  prdata = DATA_W'(segment_count);
      default:      prdata = '0;
    endcase
  end

  sfvg_front #(
    .MAX_FACES  (MAX_FACES),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .ring          (ring),
    .segment       (segment),
    .ring_count    (ring_count),
    .segment_count (segment_count),
    .busy          (busy),
    .push          (push),
    .push_data     (push_data),
    .q_stat        (q_stat)
  );

  sfvg_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  sfvg_back #(
    .ANGLE_BITS     (ANGLE_BITS),
    .SINE_FRAC_BITS (SINE_FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .radius       (radius),
    .q_stat       (q_stat),
    .pop          (pop),
    .pop_data     (pop_data),
    .valid        (valid),
    .vertex_index (vertex_index),
    .corner       (corner),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .tex_u        (tex_u),
    .tex_v        (tex_v),
    .last         (last)
  );

endmodule

>>> rtl/core/sfvg_queue.sv
// Short FIFO that decouples the face front end from the vertex back end.
module sfvg_queue #(
  parameter int WIDTH = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [WIDTH-1:0]     push_data,
  input  logic                 pop,
  output logic [WIDTH-1:0]     pop_data,
  output sfvg_pkg::q_stat_t    stat
);
  import sfvg_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]  mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wp;
  logic [PTR_W-1:0]  rp;
  logic [CNT_QW-1:0] count;

  assign pop_data   = mem[rp];
  assign stat.full  = (count == CNT_QW'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

>>> rtl/core/sfvg_front.sv
// Front end: accepts faces, drops those out of range, divides out the four angle boundaries.
module sfvg_front #(
  parameter int MAX_FACES  = sfvg_pkg::MAX_FACES_DEF,
  parameter int ANGLE_BITS = sfvg_pkg::ANGLE_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          start,
  input  logic [sfvg_pkg::IDX_W-1:0]                    ring,
  input  logic [sfvg_pkg::IDX_W-1:0]                    segment,
  input  logic [sfvg_pkg::CNT_W-1:0]                    ring_count,
  input  logic [sfvg_pkg::CNT_W-1:0]                    segment_count,
  output logic                                          busy,
  output logic                                          push,
  output logic [sfvg_pkg::VIDX_W+4*ANGLE_BITS-1:0]      push_data,
  input  sfvg_pkg::q_stat_t                             q_stat
);
  import sfvg_pkg::*;

  localparam int NCYC       = (ANGLE_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int LAST_STEPS = ANGLE_BITS - DIV_STEPS * (NCYC - 1);
  localparam int CYC_W      = $clog2(NCYC);

  logic [CNT_W-1:0]      rc;
  logic [CNT_W-1:0]      sc;
  logic [CNT_W-1:0]      lcnt      [4];
  logic [CNT_W-1:0]      dividend  [4];
  logic [CNT_W-1:0]      rem_init  [4];
  logic [CNT_W-1:0]      rem       [4];
  logic [CNT_W-1:0]      rem_next  [4];
  logic [ANGLE_BITS-1:0] quo       [4];
  logic [ANGLE_BITS-1:0] quo_next  [4];
  logic [PROD_W-1:0]     prod;
  logic [PROD_W-1:0]     prod_next;
  logic [VIDX_W-1:0]     base;
  logic [CYC_W-1:0]      cyc;
  logic                  active;
  logic                  done;
  logic                  in_range;
  logic                  accept;

  // Counts above the face limit behave as the limit itself.
  always_comb begin
    rc = ring_count;
    sc = segment_count;
    if (int'(ring_count) > MAX_FACES) rc = CNT_W'(MAX_FACES);
    if (int'(segment_count) > MAX_FACES) sc = CNT_W'(MAX_FACES);
  end

  assign in_range = ({1'b0, ring} < rc) && ({1'b0, segment} < sc);
  assign push     = active && done && !q_stat.full;
  assign busy     = active && !push;
  assign accept   = start && !busy;

  assign prod_next = PROD_W'(ring) * PROD_W'(sc) + PROD_W'(segment);
  assign base      = VIDX_W'({prod, 2'b00}) + VIDX_W'({prod, 1'b0});
  assign push_data = {base, quo[0], quo[1], quo[2], quo[3]};

  always_comb begin
    lcnt[0]     = rc;
    lcnt[1]     = rc;
    lcnt[2]     = sc;
    lcnt[3]     = sc;
    dividend[0] = {1'b0, ring};
    dividend[1] = {1'b0, ring} + 1'b1;
    dividend[2] = {1'b0, segment};
    dividend[3] = {1'b0, segment} + 1'b1;
    // The closing boundary of the last face is a full turn, which wraps to zero.
    for (int l = 0; l < 4; l++) begin
      rem_init[l] = (dividend[l] == lcnt[l]) ? '0 : dividend[l];
    end
  end

  // Restoring division, a few quotient bits per cycle in each lane.
  always_comb begin
    logic [CNT_W:0]        r2;
    logic [CNT_W-1:0]      r;
    logic [ANGLE_BITS-1:0] q;
    for (int l = 0; l < 4; l++) begin
      r = rem[l];
      q = quo[l];
      for (int j = 0; j < DIV_STEPS; j++) begin
        if ((cyc != CYC_W'(NCYC - 1)) || (j < LAST_STEPS)) begin
          r2 = {r, 1'b0};
          if (r2 >= {1'b0, lcnt[l]}) begin
            r2 = r2 - {1'b0, lcnt[l]};
            q  = {q[ANGLE_BITS-2:0], 1'b1};
          end else begin
            q  = {q[ANGLE_BITS-2:0], 1'b0};
          end
          r = r2[CNT_W-1:0];
        end
      end
      rem_next[l] = r;
      quo_next[l] = q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cyc    <= '0;
    end else begin
      if (active && !done) begin
        rem <= rem_next;
        quo <= quo_next;
        if (cyc == CYC_W'(NCYC - 1)) done <= 1'b1;
        else cyc <= cyc + 1'b1;
      end
      if (push) begin
        active <= 1'b0;
        done   <= 1'b0;
      end
      if (accept && in_range) begin
        active <= 1'b1;
        done   <= 1'b0;
        cyc    <= '0;
        rem    <= rem_init;
        prod   <= prod_next;
      end
    end
  end

endmodule

>>> rtl/core/sfvg_back.sv
// Back end: looks up sines, scales by the radius and emits the six vertices of a face.
module sfvg_back #(
  parameter int ANGLE_BITS     = sfvg_pkg::ANGLE_BITS_DEF,
  parameter int SINE_FRAC_BITS = sfvg_pkg::SINE_FRAC_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic [sfvg_pkg::RADIUS_W-1:0]                 radius,
  input  sfvg_pkg::q_stat_t                             q_stat,
  output logic                                          pop,
  input  logic [sfvg_pkg::VIDX_W+4*ANGLE_BITS-1:0]      pop_data,
  output logic                                          valid,
  output logic [sfvg_pkg::VIDX_W-1:0]                   vertex_index,
  output logic [sfvg_pkg::CORNER_W-1:0]                 corner,
  output logic signed [sfvg_pkg::POS_W-1:0]             pos_x,
  output logic signed [sfvg_pkg::POS_W-1:0]             pos_y,
  output logic signed [sfvg_pkg::POS_W-1:0]             pos_z,
  output logic                                          tex_u,
  output logic                                          tex_v,
  output logic                                          last
);
  import sfvg_pkg::*;

  localparam int SW      = SINE_FRAC_BITS + 1;
  localparam int KW      = ANGLE_BITS - 1;
  localparam int QUARTER = 1 << (ANGLE_BITS - 2);
  localparam int PW      = RADIUS_W + SW;

  // Corner order: upper theta edge and next phi edge per corner, bit c for corner c.
  localparam logic [5:0] UPPER_EDGE = 6'b100011;
  localparam logic [5:0] NEXT_EDGE  = 6'b010101;

  typedef logic [SW-1:0] rom_t [0:QUARTER];

  function automatic rom_t build_rom();
    rom_t t;
    for (int k = 0; k <= QUARTER; k++) begin
      t[k] = SW'(quarter_sine(k, ANGLE_BITS, SINE_FRAC_BITS));
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // Returns {negate, table index} for the sine or cosine of an angle.
  function automatic logic [KW:0] trig_addr(logic [ANGLE_BITS-1:0] a, logic is_cos);
    logic [ANGLE_BITS-1:0] b;
    logic [KW-1:0]         rr;
    logic [KW-1:0]         k;
    b  = is_cos ? a + ANGLE_BITS'(QUARTER) : a;
    rr = KW'(b[ANGLE_BITS-3:0]);
    k  = b[ANGLE_BITS-2] ? KW'(QUARTER) - rr : rr;
    return {b[ANGLE_BITS-1], k};
  endfunction

  typedef enum logic [2:0] {
    A_IDLE, A_COS_T, A_SIN_T, A_PHI_THIS, A_PHI_NEXT, A_LAST_DATA, A_READY
  } a_state_t;

  a_state_t a_state;

  logic [ANGLE_BITS-1:0]      a_tu, a_tl, a_ph, a_pn;
  logic [VIDX_W-1:0]          a_base;
  logic [KW:0]                sel0, sel1;
  logic [SW-1:0]              rd0, rd1;
  logic                       ng0, ng1;
  logic [PW-1:0]              pm0, pm1;
  logic [RADIUS_W-1:0]        mag0, mag1;
  logic signed [POS_W-1:0]    yv0, yv1;

  logic signed [POS_W-1:0]    a_y   [2];
  logic [RADIUS_W-1:0]        a_rsm [2];
  logic                       a_rsn [2];
  logic [SW-1:0]              a_cm  [2];
  logic                       a_cn  [2];
  logic [SW-1:0]              a_sm  [2];
  logic                       a_sn  [2];

  logic                       b_active;
  logic [CORNER_W-1:0]        b_corner;
  logic [VIDX_W-1:0]          b_base;
  logic signed [POS_W-1:0]    b_y   [2];
  logic [RADIUS_W-1:0]        b_rsm [2];
  logic                       b_rsn [2];
  logic [SW-1:0]              b_cm  [2];
  logic                       b_cn  [2];
  logic [SW-1:0]              b_sm  [2];
  logic                       b_sn  [2];

  logic                       b_free;
  logic                       handoff;
  logic                       th, ph;
  logic [PW-1:0]              pex, pez;
  logic [RADIUS_W-1:0]        mx, mz;
  logic signed [POS_W-1:0]    vx, vz;

  assign b_free  = !b_active || (b_corner == CORNER_LAST);
  assign handoff = (a_state == A_READY) && b_free;
  assign pop     = ((a_state == A_IDLE) || handoff) && !q_stat.empty;

  // Two table reads per cycle: theta cosines, theta sines, then phi of each edge.
  always_comb begin
    case (a_state)
      A_SIN_T: begin
        sel0 = trig_addr(a_tu, 1'b0);
        sel1 = trig_addr(a_tl, 1'b0);
      end
      A_PHI_THIS: begin
        sel0 = trig_addr(a_ph, 1'b1);
        sel1 = trig_addr(a_ph, 1'b0);
      end
      A_PHI_NEXT: begin
        sel0 = trig_addr(a_pn, 1'b1);
        sel1 = trig_addr(a_pn, 1'b0);
      end
      default: begin
        sel0 = trig_addr(a_tu, 1'b1);
        sel1 = trig_addr(a_tl, 1'b1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd0 <= SINE_ROM[sel0[KW-1:0]];
    rd1 <= SINE_ROM[sel1[KW-1:0]];
    ng0 <= sel0[KW];
    ng1 <= sel1[KW];
  end

  // Radius products drop the fraction and truncate toward zero.
  assign pm0  = PW'(radius) * PW'(rd0);
  assign pm1  = PW'(radius) * PW'(rd1);
  assign mag0 = pm0[SINE_FRAC_BITS +: RADIUS_W];
  assign mag1 = pm1[SINE_FRAC_BITS +: RADIUS_W];
  assign yv0  = ng0 ? -signed'({1'b0, mag0}) : signed'({1'b0, mag0});
  assign yv1  = ng1 ? -signed'({1'b0, mag1}) : signed'({1'b0, mag1});

  always_ff @(posedge clk) begin
    if (rst) begin
      a_state <= A_IDLE;
    end else begin
      case (a_state)
        A_COS_T: a_state <= A_SIN_T;
        A_SIN_T: begin
          a_y[1]  <= yv0;
          a_y[0]  <= yv1;
          a_state <= A_PHI_THIS;
        end
        A_PHI_THIS: begin
          a_rsm[1] <= mag0;
          a_rsn[1] <= ng0;
          a_rsm[0] <= mag1;
          a_rsn[0] <= ng1;
          a_state  <= A_PHI_NEXT;
        end
        A_PHI_NEXT: begin
          a_cm[0] <= rd0;
          a_cn[0] <= ng0;
          a_sm[0] <= rd1;
          a_sn[0] <= ng1;
          a_state <= A_LAST_DATA;
        end
        A_LAST_DATA: begin
          a_cm[1] <= rd0;
          a_cn[1] <= ng0;
          a_sm[1] <= rd1;
          a_sn[1] <= ng1;
          a_state <= A_READY;
        end
        A_READY: begin
          if (handoff) a_state <= A_IDLE;
        end
        A_IDLE: a_state <= A_IDLE;
        default: a_state <= A_IDLE;
      endcase
      if (pop) begin
        {a_base, a_tu, a_tl, a_ph, a_pn} <= pop_data;
        a_state <= A_COS_T;
      end
    end
  end

  assign th  = UPPER_EDGE[b_corner];
  assign ph  = NEXT_EDGE[b_corner];
  assign pex = PW'(b_rsm[th]) * PW'(b_cm[ph]);
  assign pez = PW'(b_rsm[th]) * PW'(b_sm[ph]);
  assign mx  = pex[SINE_FRAC_BITS +: RADIUS_W];
  assign mz  = pez[SINE_FRAC_BITS +: RADIUS_W];
  assign vx  = (b_rsn[th] ^ b_cn[ph]) ? -signed'({1'b0, mx}) : signed'({1'b0, mx});
  assign vz  = (b_rsn[th] ^ b_sn[ph]) ? -signed'({1'b0, mz}) : signed'({1'b0, mz});

  always_ff @(posedge clk) begin
    if (rst) begin
      b_active <= 1'b0;
      b_corner <= CORNER_FIRST;
      valid    <= 1'b0;
    end else begin
      valid <= b_active;
      if (b_active) begin
        vertex_index <= b_base + VIDX_W'(b_corner);
        corner       <= b_corner;
        pos_x        <= vx;
        pos_y        <= b_y[th];
        pos_z        <= vz;
        tex_u        <= NEXT_EDGE[b_corner];
        tex_v        <= UPPER_EDGE[b_corner];
        last         <= (b_corner == CORNER_LAST);
      end
      if (handoff) begin
        b_active <= 1'b1;
        b_corner <= CORNER_FIRST;
        b_base   <= a_base;
        b_y      <= a_y;
        b_rsm    <= a_rsm;
        b_rsn    <= a_rsn;
        b_cm     <= a_cm;
        b_cn     <= a_cn;
        b_sm     <= a_sm;
        b_sn     <= a_sn;
      end else if (b_active) begin
        if (b_corner == CORNER_LAST) b_active <= 1'b0;
        else b_corner <= b_corner + 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/sfvg_checker.sv
// Port-level checks on the vertex stream, bound to the top level.
module sfvg_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           valid,
  input logic [sfvg_pkg::VIDX_W-1:0]    vertex_index,
  input logic [sfvg_pkg::CORNER_W-1:0]  corner,
  input logic                           last
);
  import sfvg_pkg::*;

  // A face's vertices come out back to back, corners in order.
  a_corner_seq: assert property (@(posedge clk) disable iff (rst)
    valid && (corner != CORNER_LAST) |=> valid && (corner == $past(corner) + 3'd1))
    else $error("corner sequence broken inside a face");

  a_index_seq: assert property (@(posedge clk) disable iff (rst)
    valid && (corner != CORNER_LAST) |=> vertex_index == $past(vertex_index) + 19'd1)
    else $error("vertex index does not advance within a face");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    valid |-> (last == (corner == CORNER_LAST)))
    else $error("last flag disagrees with the corner");

  a_first_corner: assert property (@(posedge clk) disable iff (rst)
    valid && !$past(valid) |-> corner == CORNER_FIRST)
    else $error("a burst of vertices did not start at the first corner");

endmodule

bind sphere_face_vertex_generator_top sfvg_checker u_sfvg_checker (
  .clk          (clk),
  .rst          (rst),
  .valid        (valid),
  .vertex_index (vertex_index),
  .corner       (corner),
  .last         (last)
);

>>> test/sphere_face_vertex_generator_top_test.sv
// Self-checking testbench of the sphere face vertex generator top level.
`timescale 1ns / 1ps

module sphere_face_vertex_generator_top_test;
  import sfvg_pkg::*;

  localparam int MAX_FACES      = 256;
  localparam int ANGLE_BITS     = 12;
  localparam int SINE_FRAC_BITS = 14;
  localparam int QUARTER        = 1 << (ANGLE_BITS - 2);
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;

  // One vertex as it appears on the result ports.
  typedef struct packed {
    logic [VIDX_W-1:0]   vidx;
    logic [CORNER_W-1:0] crn;
    logic [POS_W-1:0]    px;
    logic [POS_W-1:0]    py;
    logic [POS_W-1:0]    pz;
    logic                u;
    logic                v;
    logic                lst;
  } vertex_t;

  // A directed stimulus row; when has_vertex0 is set, corner zero is also typed in.
  typedef struct {
    logic [IDX_W-1:0] ring_i;
    logic [IDX_W-1:0] seg_i;
    bit               has_vertex0;
    vertex_t          vertex0;
  } face_row_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                start;
  logic                busy;
  logic [IDX_W-1:0]    ring;
  logic [IDX_W-1:0]    segment;
  logic                valid;
  logic [VIDX_W-1:0]   vertex_index;
  logic [CORNER_W-1:0] corner;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic                tex_u;
  logic                tex_v;
  logic                last;

  // Local copy of the configuration registers used by the vertex predictor.
  logic [RADIUS_W-1:0] radius_q;
  logic [CNT_W-1:0]    ring_count_q;
  logic [CNT_W-1:0]    seg_count_q;

  vertex_t pending_vertices[$];
  vertex_t typed_vertex0[$];
  bit      typed_flag[$];
  int      error_count;
  int      idle_cycles;
  bit      no_gaps;
  bit      timed_out;

  longint  sine_table[QUARTER+1];

  sphere_face_vertex_generator_top #(
    .MAX_FACES(MAX_FACES),
    .ANGLE_BITS(ANGLE_BITS),
    .SINE_FRAC_BITS(SINE_FRAC_BITS)
  ) u_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .ring(ring), .segment(segment),
    .valid(valid), .vertex_index(vertex_index), .corner(corner),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .tex_u(tex_u), .tex_v(tex_v), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Quarter-wave sine entry, computed independently by the same Q.30 Taylor series.
  function automatic longint table_entry(int k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned rounded;
    longint          acc;
    x = (longint'(k) * 64'd6746518852) >> ANGLE_BITS;
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      term = (term * x2) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n[0]) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    rounded = ((unsigned'(acc) << SINE_FRAC_BITS) + (64'd1 << 29)) >> 30;
    if (rounded > (64'd1 << SINE_FRAC_BITS)) rounded = 64'd1 << SINE_FRAC_BITS;
    return longint'(rounded);
  endfunction

  function automatic longint sin_angle(int unsigned a);
    int unsigned quad;
    int unsigned rem;
    longint      s;
    a = a & ((1 << ANGLE_BITS) - 1);
    quad = a >> (ANGLE_BITS - 2);
    rem = a & (QUARTER - 1);
    s = quad[0] ? sine_table[QUARTER - rem] : sine_table[rem];
    return quad[1] ? -s : s;
  endfunction

  function automatic longint cos_angle(int unsigned a);
    return sin_angle(a + QUARTER);
  endfunction

  // Product with a sine value, fraction dropped and truncated toward zero.
  function automatic longint scale_by_sine(longint a, longint s);
    longint p;
    p = a * s;
    if (p >= 0) return p >>> SINE_FRAC_BITS;
    return -((-p) >>> SINE_FRAC_BITS);
  endfunction

  function automatic int unsigned face_edge_angle(int unsigned i, int unsigned cnt);
    return (longint'(i) << ANGLE_BITS) / cnt;
  endfunction

  // True when the face lies inside the programmed counts and so produces vertices.
  function automatic bit face_in_range(logic [IDX_W-1:0] r_i, logic [IDX_W-1:0] s_i);
    int unsigned rc;
    int unsigned sc;
    rc = (ring_count_q > MAX_FACES) ? MAX_FACES : ring_count_q;
    sc = (seg_count_q > MAX_FACES) ? MAX_FACES : seg_count_q;
    return (r_i < rc) && (s_i < sc);
  endfunction

  // Appends the six vertices of a face to the expectation queue, or nothing when the
  // face lies outside the programmed counts.
  function automatic void predict_face_vertices(logic [IDX_W-1:0] r_i, logic [IDX_W-1:0] s_i);
    int unsigned rc;
    int unsigned sc;
    longint      rad;
    longint      y_e[2];
    longint      rs_e[2];
    longint      cp_e[2];
    longint      sp_e[2];
    longint      base;
    bit          upper;
    bit          nxt;
    vertex_t     vx;
    rc = (ring_count_q > MAX_FACES) ? MAX_FACES : ring_count_q;
    sc = (seg_count_q > MAX_FACES) ? MAX_FACES : seg_count_q;
    if (r_i >= rc || s_i >= sc) return;
    rad = radius_q;
    // Index one is the upper theta edge, index zero the lower one.
    y_e[1]  = scale_by_sine(rad, cos_angle(face_edge_angle(r_i, rc)));
    y_e[0]  = scale_by_sine(rad, cos_angle(face_edge_angle(r_i + 1, rc)));
    rs_e[1] = scale_by_sine(rad, sin_angle(face_edge_angle(r_i, rc)));
    rs_e[0] = scale_by_sine(rad, sin_angle(face_edge_angle(r_i + 1, rc)));
    cp_e[0] = cos_angle(face_edge_angle(s_i, sc));
    sp_e[0] = sin_angle(face_edge_angle(s_i, sc));
    cp_e[1] = cos_angle(face_edge_angle(s_i + 1, sc));
    sp_e[1] = sin_angle(face_edge_angle(s_i + 1, sc));
    base = 6 * (longint'(r_i) * sc + s_i);
    for (int c = 0; c < 6; c++) begin
      upper = (c == 0 || c == 1 || c == 5);
      nxt = (c == 0 || c == 2 || c == 4);
      vx.vidx = VIDX_W'(base + c);
      vx.crn  = CORNER_W'(c);
      vx.px   = POS_W'(scale_by_sine(rs_e[upper], cp_e[nxt]));
      vx.py   = POS_W'(y_e[upper]);
      vx.pz   = POS_W'(scale_by_sine(rs_e[upper], sp_e[nxt]));
      vx.u    = nxt;
      vx.v    = upper;
      vx.lst  = (c == 5);
      pending_vertices.push_back(vx);
    end
  endfunction

  // Register write through the APB port: a setup cycle, then the access cycle.
  task automatic write_register(logic [1:0] idx, logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_RADIUS:   radius_q = value[RADIUS_W-1:0];
      REG_RING_CNT: ring_count_q = value[CNT_W-1:0];
      REG_SEG_CNT:  seg_count_q = value[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_sphere(int rad, int rc, int sc);
    write_register(REG_RADIUS, DATA_W'(rad));
    write_register(REG_RING_CNT, DATA_W'(rc));
    write_register(REG_SEG_CNT, DATA_W'(sc));
  endtask

  // Waits until all expected vertices have arrived, then lets any out-of-range face
  // still in flight finish before the configuration is touched.
  task automatic drain_block();
    while (pending_vertices.size() != 0 && !timed_out) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Issues one face transaction, with a random gap before it unless gaps are off.
  task automatic send_face(logic [IDX_W-1:0] r_i, logic [IDX_W-1:0] s_i);
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    start <= 1'b1;
    ring <= r_i;
    segment <= s_i;
    @(posedge clk);
    while (busy && !timed_out) @(posedge clk);
    predict_face_vertices(r_i, s_i);
  endtask

  // Only faces that produce vertices get an entry in the typed-vertex queues.
  task automatic run_directed(const ref face_row_t rows[$]);
    foreach (rows[i]) begin
      send_face(rows[i].ring_i, rows[i].seg_i);
      if (face_in_range(rows[i].ring_i, rows[i].seg_i)) begin
        typed_flag.push_back(rows[i].has_vertex0);
        if (rows[i].has_vertex0) typed_vertex0.push_back(rows[i].vertex0);
      end
    end
    start <= 1'b0;
  endtask

  // Result monitor: every strobe is checked against the oldest expected vertex.
  always @(posedge clk) begin
    vertex_t got;
    vertex_t want;
    if (!rst && valid) begin
      got = '{vertex_index, corner, pos_x, pos_y, pos_z, tex_u, tex_v, last};
      if (pending_vertices.size() == 0) begin
        $display("%0t: unexpected vertex %h", $time, got);
        error_count++;
      end else begin
        want = pending_vertices.pop_front();
        if (got !== want) begin
          $display("%0t: vertex mismatch expected %h actual %h", $time, want, got);
          error_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles with neither a face accepted nor a vertex delivered.
  always @(posedge clk) begin
    if (rst || valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    face_row_t rows[$];
    face_row_t row;
    int        rad;
    int        rc;
    int        sc;
    int        steps;
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] s_i;

    for (int k = 0; k <= QUARTER; k++) sine_table[k] = table_entry(k);
    error_count = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    no_gaps = 1'b0;
    radius_q = '0;
    ring_count_q = '0;
    seg_count_q = '0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    start = 1'b0;
    ring = '0;
    segment = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // After reset both counts are zero, so every face is out of range and silent.
    rows = {};
    row = '{8'd0, 8'd0, 1'b0, '0};
    rows.push_back(row);
    row = '{8'd255, 8'd255, 1'b0, '0};
    rows.push_back(row);
    run_directed(rows);
    drain_block();

    // One ring, one segment, full radius: the upper edge sits at angle zero,
    // so corner zero is (0, radius, 0) and the closing boundary wraps to zero.
    program_sphere(16'hFFFF, 1, 1);
    rows = {};
    row = '{8'd0, 8'd0, 1'b1, '{19'd0, 3'd0, 17'd0, 17'd65535, 17'd0, 1'b1, 1'b1, 1'b0}};
    rows.push_back(row);
    row = '{8'd1, 8'd0, 1'b0, '0};
    rows.push_back(row);
    row = '{8'd0, 8'd1, 1'b0, '0};
    rows.push_back(row);
    run_directed(rows);
    drain_block();

    // Counts above the face limit are clamped; face (255, 255) gives the highest vertex
    // index, which still fits its width.
    program_sphere(16'h0100, 511, 511);
    rows = {};
    row = '{8'd255, 8'd255, 1'b0, '0};
    rows.push_back(row);
    row = '{8'd0, 8'd0, 1'b1, '{19'd0, 3'd0, 17'd0, 17'd256, 17'd0, 1'b1, 1'b1, 1'b0}};
    rows.push_back(row);
    row = '{8'd128, 8'd64, 1'b0, '0};
    rows.push_back(row);
    row = '{8'd85, 8'd170, 1'b0, '0};
    rows.push_back(row);
    run_directed(rows);
    drain_block();

    // Zero radius gives all-zero positions; exact limit counts of 256.
    program_sphere(0, 256, 256);
    rows = {};
    row = '{8'd17, 8'd200, 1'b0, '0};
    rows.push_back(row);
    row = '{8'd255, 8'd0, 1'b0, '0};
    rows.push_back(row);
    run_directed(rows);
    drain_block();

    // Random phases, each with its own sphere setting; the last runs without gaps.
    for (int phase = 0; phase < 7; phase++) begin
      rad = (phase == 0) ? 16'hFFFF : $urandom_range(0, 16'hFFFF);
      rc = (phase == 1) ? 511 : $urandom_range(0, 300);
      sc = (phase == 1) ? 256 : $urandom_range(0, 300);
      if (phase == 2) begin
        rc = $urandom_range(1, 12);
        sc = $urandom_range(1, 12);
      end
      program_sphere(rad, rc, sc);
      no_gaps = (phase == 6);
      steps = 30;
      for (int n = 0; n < steps; n++) begin
        // Mostly faces inside the counts; the rest are random indexes.
        if ($urandom_range(0, 4) != 0 && rc > 0 && sc > 0) begin
          r_i = $urandom_range(0, ((rc > 256) ? 256 : rc) - 1);
          s_i = $urandom_range(0, ((sc > 256) ? 256 : sc) - 1);
        end else begin
          r_i = $urandom_range(0, 255);
          s_i = $urandom_range(0, 255);
        end
        send_face(r_i, s_i);
      end
      start <= 1'b0;
      drain_block();
    end

    if (pending_vertices.size() != 0) begin
      $display("%0t: %0d expected vertices never arrived", $time, pending_vertices.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Corner zero of directed rows with a typed vertex is also checked against the typed
  // copy, which catches a predictor that drifted from the intended numbers.
  always @(posedge clk) begin
    vertex_t t;
    if (!rst && valid && corner == CORNER_FIRST && typed_flag.size() != 0) begin
      if (typed_flag.pop_front()) begin
        t = typed_vertex0.pop_front();
        if ({vertex_index, corner, pos_x, pos_y, pos_z, tex_u, tex_v, last} !== t) begin
          $display("%0t: typed vertex expected %h actual %h", $time, t,
                   {vertex_index, corner, pos_x, pos_y, pos_z, tex_u, tex_v, last});
          error_count++;
        end
      end
    end
  end

endmodule

>>> sphere_face_vertex_generator_top.f
rtl/core/sfvg_pkg.sv
rtl/core/sfvg_queue.sv
rtl/core/sfvg_front.sv
rtl/core/sfvg_back.sv
rtl/core/sphere_face_vertex_generator_top.sv
rtl/core/sfvg_checker.sv
test/sphere_face_vertex_generator_top_test.sv
